@@ rtl/core/mbph_pkg.sv @@
// shared types, constants and helpers of the meter ballistics block
package mbph_pkg;

  // number formats
  localparam int FRAC_BITS = 10;
  localparam int VAL_W     = 21;
  localparam int NARROW_W  = 17;
  localparam int GAIN_W    = 16;
  localparam int FUNC_W    = 3;
  localparam int CH_N      = 4;
  localparam int CH_W      = 2;
  localparam int HELD_N    = 3;
  localparam int CFG_IDX_W = 2;
  localparam int PROD_W    = VAL_W + GAIN_W;

  // depth of the result queue, enough to cover the pipeline at full rate
  localparam int RES_DEPTH_DEF = 5;

  // one in the value grid
  localparam int ONE = 1 << FRAC_BITS;

  // clamp limits
  localparam logic [VAL_W-1:0] FWD_MAX = VAL_W'(ONE * 1500);
  localparam logic [VAL_W-1:0] PCT_MAX = VAL_W'(ONE * 100);
  localparam logic [VAL_W-1:0] SWR_MIN = VAL_W'(ONE);
  localparam logic [VAL_W-1:0] SWR_MAX = VAL_W'(ONE * 64);

  // settle thresholds, rounded to the grid
  localparam logic [VAL_W-1:0] SETTLE_EPS = VAL_W'((ONE + 500) / 1000);
  localparam logic [VAL_W-1:0] PEAK_EPS   = VAL_W'((ONE + 50) / 100);

  // gain register reset values
  localparam logic [GAIN_W-1:0] ATTACK_RST     = GAIN_W'(32768);
  localparam logic [GAIN_W-1:0] DECAY_RST      = GAIN_W'(16384);
  localparam logic [GAIN_W-1:0] PEAK_DECAY_RST = GAIN_W'(3277);

  // item codes
  typedef enum logic [FUNC_W-1:0] {
    FUNC_FWD  = 3'd0,
    FUNC_REFL = 3'd1,
    FUNC_SWR  = 3'd2,
    FUNC_TEMP = 3'd3,
    FUNC_TICK = 3'd4,
    FUNC_DISC = 3'd5
  } func_e;

  // meter channels
  typedef enum logic [CH_W-1:0] {
    CH_FWD  = 2'd0,
    CH_REFL = 2'd1,
    CH_SWR  = 2'd2,
    CH_TEMP = 2'd3
  } ch_e;

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ATTACK     = 2'd0,
    CFG_DECAY      = 2'd1,
    CFG_PEAK_DECAY = 2'd2
  } cfg_idx_e;

  // per-channel minimum steps
  localparam logic [VAL_W-1:0] ANIM_MIN [CH_N] = '{
    VAL_W'(ONE * 2),
    VAL_W'((ONE * 2 + 5) / 10),
    VAL_W'((ONE + 50) / 100),
    VAL_W'((ONE * 2 + 5) / 10)
  };
  localparam logic [VAL_W-1:0] PEAK_MIN [CH_N] = '{
    VAL_W'(ONE),
    VAL_W'((ONE + 5) / 10),
    VAL_W'((ONE + 100) / 200),
    VAL_W'(0)
  };

  // reset values of the display and peak bank
  localparam logic [VAL_W-1:0] DISP_RST [CH_N] = '{
    VAL_W'(0), VAL_W'(0), SWR_MIN, VAL_W'(0)
  };
  localparam logic [VAL_W-1:0] PEAK_RST [HELD_N] = '{
    VAL_W'(0), VAL_W'(0), SWR_MIN
  };

  // one channel record as kept in the state memory
  typedef struct packed {
    logic [VAL_W-1:0] tgt;
    logic [VAL_W-1:0] disp;
    logic [VAL_W-1:0] peak;
  } rec_t;

  // gain registers
  typedef struct packed {
    logic [GAIN_W-1:0] attack;
    logic [GAIN_W-1:0] decay;
    logic [GAIN_W-1:0] peak_decay;
  } gains_t;

  // one accepted input item
  typedef struct packed {
    func_e            func;
    logic [VAL_W-1:0] value;
  } item_t;

  // one result item
  typedef struct packed {
    logic [VAL_W-1:0]    shown_forward;
    logic [NARROW_W-1:0] shown_reflected;
    logic [NARROW_W-1:0] shown_swr;
    logic [NARROW_W-1:0] shown_temperature;
    logic [VAL_W-1:0]    held_forward;
    logic [NARROW_W-1:0] held_reflected;
    logic [NARROW_W-1:0] held_swr;
    logic                animating;
  } result_t;

  // record of a channel after reset or disconnect
  function automatic rec_t rst_rec(input ch_e ch);
    rec_t r;
    r = '0;
    if (ch == CH_SWR) begin
      r.tgt  = SWR_MIN;
      r.disp = SWR_MIN;
      r.peak = SWR_MIN;
    end
    return r;
  endfunction

  // clamp a sample to its channel range
  function automatic logic [VAL_W-1:0] clamp_sample(input ch_e ch,
                                                    input logic [VAL_W-1:0] v);
    logic [VAL_W-1:0] r;
    r = v;
    case (ch)
      CH_FWD: begin
        if (v > FWD_MAX) r = FWD_MAX;
      end
      CH_SWR: begin
        if (v < SWR_MIN) r = SWR_MIN;
        else if (v > SWR_MAX) r = SWR_MAX;
      end
      default: begin
        if (v > PCT_MAX) r = PCT_MAX;
      end
    endcase
    return r;
  endfunction

endpackage

@@ rtl/core/mbph_if.sv @@
// handshake channels of the meter ballistics block
interface mbph_item_if import mbph_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [FUNC_W-1:0]   func;
  logic [VAL_W-1:0]    value;

  modport source (output valid, func, value, input ready);
  modport sink (input valid, func, value, output ready);
endinterface

interface mbph_result_if import mbph_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [VAL_W-1:0]    shown_forward;
  logic [NARROW_W-1:0] shown_reflected;
  logic [NARROW_W-1:0] shown_swr;
  logic [NARROW_W-1:0] shown_temperature;
  logic [VAL_W-1:0]    held_forward;
  logic [NARROW_W-1:0] held_reflected;
  logic [NARROW_W-1:0] held_swr;
  logic                animating;

  modport source (output valid, shown_forward, shown_reflected, shown_swr,
                  shown_temperature, held_forward, held_reflected, held_swr,
                  animating, input ready);
  modport sink (input valid, shown_forward, shown_reflected, shown_swr,
                shown_temperature, held_forward, held_reflected, held_swr,
                animating, output ready);
endinterface

interface mbph_cfg_if import mbph_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [GAIN_W-1:0]    data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

@@ rtl/core/mbph_core.sv @@
// channel state memory with issue, multiply and update stages
module mbph_core import mbph_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    load_i,
  input  item_t   item_i,
  input  gains_t  gains_i,
  output logic    free_o,
  output logic    push_o,
  output result_t res_o
);

  // issue stage
  logic             iss_valid_q;
  func_e            iss_func_q;
  logic [VAL_W-1:0] iss_value_q;
  ch_e              iss_ch_q;
  logic             iss_last;
  logic             iss_adv;
  logic             hazard;

  // multiply stage
  logic             e1_valid_q;
  func_e            e1_func_q;
  logic [VAL_W-1:0] e1_value_q;
  ch_e              e1_ch_q;
  logic             e1_last_q;
  logic             fwd_hit_q;
  rec_t             fwd_rec_q;
  logic             rd_ok_q;
  rec_t             e1_rec;
  logic             e1_rising;
  logic [VAL_W-1:0] e1_diff;
  logic [GAIN_W-1:0] e1_gain;
  logic [PROD_W-1:0] prod_a;
  logic [PROD_W-1:0] prod_p;

  // update stage
  logic             e2_valid_q;
  func_e            e2_func_q;
  ch_e              e2_ch_q;
  logic             e2_last_q;
  rec_t             e2_rec_q;
  logic             e2_rising_q;
  logic [VAL_W-1:0] e2_diff_q;
  logic [VAL_W-1:0] e2_step_a_q;
  logic [VAL_W-1:0] e2_step_p_q;
  logic [VAL_W-1:0] e2_tgt_q;

  // state memory and flags
  rec_t             mem_q [CH_N];
  rec_t             mem_rd_q;
  logic [CH_N-1:0]  ent_valid_q, ent_valid_d;
  logic             armed_q, armed_d;
  logic             moved_acc_q, moved_acc_d;
  logic [VAL_W-1:0] disp_q [CH_N];
  logic [VAL_W-1:0] disp_d [CH_N];
  logic [VAL_W-1:0] peak_q [HELD_N];
  logic [VAL_W-1:0] peak_d [HELD_N];

  // update stage working values
  logic             mem_we;
  rec_t             mem_wrec;
  logic             e2_clear;
  logic [VAL_W-1:0] anim_min;
  logic [VAL_W-1:0] peak_min;
  logic             settle;
  logic [VAL_W-1:0] step_a;
  logic [VAL_W-1:0] disp_new;
  logic             has_peak;
  logic [VAL_W:0]   peak_room;
  logic             peak_hold;
  logic [VAL_W-1:0] step_p;
  logic [VAL_W-1:0] gap;
  logic [VAL_W-1:0] peak_new;
  logic [VAL_W-1:0] peak_smp;
  logic             moved_all;

  // issue control: a tick walks all channels, other items take one slot
  assign iss_last = (iss_func_q != FUNC_TICK) || (iss_ch_q == CH_TEMP);
  assign hazard   = e1_valid_q && ((e1_func_q == FUNC_DISC) || (e1_ch_q == iss_ch_q));
  assign iss_adv  = iss_valid_q && !hazard;
  assign free_o   = !iss_valid_q || (iss_adv && iss_last);
  assign e2_clear = e2_valid_q && (e2_func_q == FUNC_DISC);

  // issue stage registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      iss_valid_q <= 1'b0;
    end else if (load_i) begin
      iss_valid_q <= 1'b1;
    end else if (iss_adv && iss_last) begin
      iss_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      iss_func_q  <= item_i.func;
      iss_value_q <= item_i.value;
      iss_ch_q    <= (item_i.func == FUNC_TICK) ? CH_FWD
                                                : ch_e'(item_i.func[CH_W-1:0]);
    end else if (iss_adv) begin
      iss_ch_q <= ch_e'(iss_ch_q + CH_W'(1));
    end
  end

  // state memory: one write and one registered read per cycle
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[e2_ch_q] <= mem_wrec;
    end
    mem_rd_q <= mem_q[iss_ch_q];
  end

  // forwarding of a same-cycle write and entry validity for the read
  always_ff @(posedge clk_i) begin
    fwd_hit_q <= mem_we && (e2_ch_q == iss_ch_q);
    fwd_rec_q <= mem_wrec;
    rd_ok_q   <= ent_valid_q[iss_ch_q] && !e2_clear;
  end

  // multiply stage registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      e1_valid_q <= 1'b0;
    end else begin
      e1_valid_q <= iss_adv;
    end
  end

  always_ff @(posedge clk_i) begin
    if (iss_adv) begin
      e1_func_q  <= iss_func_q;
      e1_value_q <= iss_value_q;
      e1_ch_q    <= iss_ch_q;
      e1_last_q  <= iss_last;
    end
  end

  // multiply stage: resolve the record, distance to target, both products
  always_comb begin
    if (fwd_hit_q) begin
      e1_rec = fwd_rec_q;
    end else if (rd_ok_q) begin
      e1_rec = mem_rd_q;
    end else begin
      e1_rec = rst_rec(e1_ch_q);
    end
    e1_rising = e1_rec.tgt > e1_rec.disp;
    e1_diff   = e1_rising ? (e1_rec.tgt - e1_rec.disp) : (e1_rec.disp - e1_rec.tgt);
    e1_gain   = e1_rising ? gains_i.attack : gains_i.decay;
    prod_a    = PROD_W'(e1_diff) * PROD_W'(e1_gain);
    prod_p    = PROD_W'(e1_rec.peak) * PROD_W'(gains_i.peak_decay);
  end

  // update stage registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      e2_valid_q <= 1'b0;
    end else begin
      e2_valid_q <= e1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (e1_valid_q) begin
      e2_func_q   <= e1_func_q;
      e2_ch_q     <= e1_ch_q;
      e2_last_q   <= e1_last_q;
      e2_rec_q    <= e1_rec;
      e2_rising_q <= e1_rising;
      e2_diff_q   <= e1_diff;
      e2_step_a_q <= prod_a[PROD_W-1:GAIN_W];
      e2_step_p_q <= prod_p[PROD_W-1:GAIN_W];
      e2_tgt_q    <= clamp_sample(e1_ch_q, e1_value_q);
    end
  end

  // update stage: display step, peak decay, sample capture, disconnect clear, write back
  always_comb begin
    anim_min  = ANIM_MIN[e2_ch_q];
    peak_min  = PEAK_MIN[e2_ch_q];
    settle    = e2_diff_q <= SETTLE_EPS;
    step_a    = (e2_step_a_q < anim_min) ? anim_min : e2_step_a_q;
    if (settle) begin
      disp_new = e2_rec_q.disp;
    end else if (step_a >= e2_diff_q) begin
      disp_new = e2_rec_q.tgt;
    end else if (e2_rising_q) begin
      disp_new = e2_rec_q.disp + step_a;
    end else begin
      disp_new = e2_rec_q.disp - step_a;
    end

    has_peak  = e2_ch_q != CH_TEMP;
    peak_room = {1'b0, disp_new} + {1'b0, PEAK_EPS};
    peak_hold = !has_peak || ({1'b0, e2_rec_q.peak} <= peak_room);
    step_p    = (e2_step_p_q < peak_min) ? peak_min : e2_step_p_q;
    gap       = e2_rec_q.peak - disp_new;
    if (peak_hold) begin
      peak_new = e2_rec_q.peak;
    end else if (step_p >= gap) begin
      peak_new = disp_new;
    end else begin
      peak_new = e2_rec_q.peak - step_p;
    end
    moved_all = !settle || !peak_hold || ((e2_ch_q != CH_FWD) && moved_acc_q);
    peak_smp  = (has_peak && (e2_tgt_q > e2_rec_q.peak)) ? e2_tgt_q : e2_rec_q.peak;

    mem_we      = 1'b0;
    mem_wrec    = e2_rec_q;
    armed_d     = armed_q;
    moved_acc_d = moved_acc_q;
    ent_valid_d = ent_valid_q;
    disp_d      = disp_q;
    peak_d      = peak_q;

    if (e2_valid_q) begin
      case (e2_func_q)
        FUNC_FWD, FUNC_REFL, FUNC_SWR, FUNC_TEMP: begin
          mem_we        = 1'b1;
          mem_wrec.tgt  = e2_tgt_q;
          mem_wrec.peak = peak_smp;
          armed_d       = 1'b1;
          if (has_peak) begin
            peak_d[e2_ch_q] = peak_smp;
          end
        end
        FUNC_TICK: begin
          if (armed_q) begin
            mem_we          = 1'b1;
            mem_wrec.disp   = disp_new;
            mem_wrec.peak   = peak_new;
            disp_d[e2_ch_q] = disp_new;
            if (has_peak) begin
              peak_d[e2_ch_q] = peak_new;
            end
            moved_acc_d = moved_all;
            if (e2_last_q && !moved_all) begin
              armed_d = 1'b0;
            end
          end
        end
        FUNC_DISC: begin
          ent_valid_d = '0;
          disp_d      = DISP_RST;
          peak_d      = PEAK_RST;
          armed_d     = 1'b0;
          moved_acc_d = 1'b0;
        end
        default: begin
        end
      endcase
    end

    if (mem_we) begin
      ent_valid_d[e2_ch_q] = 1'b1;
    end
  end

  // flags and the display and peak bank
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ent_valid_q <= '0;
      armed_q     <= 1'b0;
      moved_acc_q <= 1'b0;
      disp_q      <= DISP_RST;
      peak_q      <= PEAK_RST;
    end else begin
      ent_valid_q <= ent_valid_d;
      armed_q     <= armed_d;
      moved_acc_q <= moved_acc_d;
      disp_q      <= disp_d;
      peak_q      <= peak_d;
    end
  end

  // result of the item whose last slot completes
  assign push_o = e2_valid_q && e2_last_q;

  always_comb begin
    res_o.shown_forward     = disp_d[CH_FWD];
    res_o.shown_reflected   = disp_d[CH_REFL][NARROW_W-1:0];
    res_o.shown_swr         = disp_d[CH_SWR][NARROW_W-1:0];
    res_o.shown_temperature = disp_d[CH_TEMP][NARROW_W-1:0];
    res_o.held_forward      = peak_d[CH_FWD];
    res_o.held_reflected    = peak_d[CH_REFL][NARROW_W-1:0];
    res_o.held_swr          = peak_d[CH_SWR][NARROW_W-1:0];
    res_o.animating         = armed_d;
  end

endmodule

@@ rtl/core/mbph_result_fifo.sv @@
// queue of finished result items toward the output channel
module mbph_result_fifo import mbph_pkg::*; #(
  parameter int DEPTH = RES_DEPTH_DEF
) (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    push_i,
  input  result_t data_i,
  output logic    valid_o,
  input  logic    ready_i,
  output result_t data_o
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  result_t          ent_q [DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [CNT_W-1:0] cnt_q;
  logic             pop;

  assign valid_o = cnt_q != '0;
  assign pop     = valid_o && ready_i;
  assign data_o  = ent_q[rd_ptr_q];

  // entry storage
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      ent_q[wr_ptr_q] <= data_i;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
      end
      cnt_q <= cnt_q + CNT_W'(push_i) - CNT_W'(pop);
    end
  end

endmodule

@@ rtl/core/meter_ballistics_peak_hold.sv @@
// Four-channel meter ballistics (forward, reflected, SWR, temperature) with
// attack/decay animation and peak hold. Channel records live in a four-entry
// state memory with a registered read; items flow through issue, multiply
// and update stages. A sample, a disconnect or an unused code takes one
// issue slot, a tick one per channel (one memory read per channel through
// the single read port), so items other than ticks sustain one per cycle
// while the result queue has room; an item that reads the channel of the
// item just ahead of it, or follows a disconnect, waits in the issue stage
// until that item leaves the multiply stage. A result passes the multiply
// and update stages into a RES_DEPTH-entry queue; at most RES_DEPTH items
// are accepted but not yet delivered. Configuration writes are always accepted.
module meter_ballistics_peak_hold import mbph_pkg::*; #(
  parameter int RES_DEPTH = RES_DEPTH_DEF
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  mbph_item_if.sink      item_i,
  mbph_result_if.source  result_o,
  mbph_cfg_if.sink       cfg_i
);

  localparam int PEND_W = $clog2(RES_DEPTH + 1);

  gains_t            gains_q;
  logic [PEND_W-1:0] pend_q;
  logic              core_free;
  logic              in_acc;
  logic              out_acc;
  item_t             item;
  logic              push;
  result_t           res_push;
  result_t           res_head;
  logic              res_valid;

  // input handshake: issue stage free and room left in the result queue
  assign item_i.ready = core_free && (pend_q != PEND_W'(RES_DEPTH));
  assign in_acc       = item_i.valid && item_i.ready;
  assign out_acc      = res_valid && result_o.ready;
  assign item.func    = func_e'(item_i.func);
  assign item.value   = item_i.value;

  // configuration registers
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gains_q.attack     <= ATTACK_RST;
      gains_q.decay      <= DECAY_RST;
      gains_q.peak_decay <= PEAK_DECAY_RST;
    end else if (cfg_i.valid) begin
      case (cfg_idx_e'(cfg_i.index))
        CFG_ATTACK:     gains_q.attack     <= cfg_i.data;
        CFG_DECAY:      gains_q.decay      <= cfg_i.data;
        CFG_PEAK_DECAY: gains_q.peak_decay <= cfg_i.data;
        default: begin
        end
      endcase
    end
  end

  // items accepted and not yet delivered
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= '0;
    end else begin
      pend_q <= pend_q + PEND_W'(in_acc) - PEND_W'(out_acc);
    end
  end

  // datapath around the state memory
  mbph_core u_core (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .load_i  (in_acc),
    .item_i  (item),
    .gains_i (gains_q),
    .free_o  (core_free),
    .push_o  (push),
    .res_o   (res_push)
  );

  // result queue
  mbph_result_fifo #(
    .DEPTH (RES_DEPTH)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (res_push),
    .valid_o (res_valid),
    .ready_i (result_o.ready),
    .data_o  (res_head)
  );

  // output channel
  assign result_o.valid             = res_valid;
  assign result_o.shown_forward     = res_head.shown_forward;
  assign result_o.shown_reflected   = res_head.shown_reflected;
  assign result_o.shown_swr         = res_head.shown_swr;
  assign result_o.shown_temperature = res_head.shown_temperature;
  assign result_o.held_forward      = res_head.held_forward;
  assign result_o.held_reflected    = res_head.held_reflected;
  assign result_o.held_swr          = res_head.held_swr;
  assign result_o.animating         = res_head.animating;

endmodule

@@ rtl/core/mbph_checker.sv @@
// port-level checks of the meter ballistics block and their binding
module mbph_checker import mbph_pkg::*; (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                in_valid,
  input logic                in_ready,
  input logic                out_valid,
  input logic                out_ready,
  input logic [VAL_W-1:0]    shown_forward,
  input logic [VAL_W-1:0]    held_forward,
  input logic [NARROW_W-1:0] shown_swr,
  input logic [NARROW_W-1:0] held_swr,
  input logic                animating
);

  logic [7:0] pend_q;

  // items seen going in minus results seen going out
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= '0;
    end else begin
      pend_q <= pend_q + 8'(in_valid && in_ready) - 8'(out_valid && out_ready);
    end
  end

  // a stalled result stays offered
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  // a stalled result keeps its forward display, forward peak and animating flag
  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !out_ready |=> $stable(shown_forward) && $stable(held_forward)
                                && $stable(animating))
    else $error("result payload changed while stalled");

  // no result without an item behind it
  a_no_extra: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid |-> pend_q != 8'd0)
    else $error("result without an accepted item");

  // swr display and peak of an offered result never drop below one
  a_swr_floor: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid |-> (shown_swr >= SWR_MIN[NARROW_W-1:0]) && (held_swr >= SWR_MIN[NARROW_W-1:0]))
    else $error("swr below one");

endmodule

bind meter_ballistics_peak_hold mbph_checker u_mbph_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_valid      (item_i.valid),
  .in_ready      (item_i.ready),
  .out_valid     (result_o.valid),
  .out_ready     (result_o.ready),
  .shown_forward (result_o.shown_forward),
  .held_forward  (result_o.held_forward),
  .shown_swr     (result_o.shown_swr),
  .held_swr      (result_o.held_swr),
  .animating     (result_o.animating)
);
